>>> hdl/tga_pkg.sv
`timescale 1ns / 1ps

package tga_pkg;

    localparam int unsigned HDR_LEN    = 12;
    localparam logic [7:0]  DEPTH_24   = 8'd24;
    localparam logic [7:0]  DEPTH_32   = 8'd32;
    localparam logic [7:0]  OPAQUE     = 8'd255;
    localparam int unsigned TDATA_BITS = 104;

    typedef enum logic [1:0] {
        KIND_HEADER = 2'd0,
        KIND_PIXEL  = 2'd1,
        KIND_ERROR  = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ERR_NONE     = 2'd0,
        ERR_MISMATCH = 2'd1,
        ERR_SIZE     = 2'd2,
        ERR_DEPTH    = 2'd3
    } err_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_of_file;
    } item_t;

    typedef struct packed {
        kind_t       kind;
        err_t        error_code;
        logic [15:0] image_width;
        logic [15:0] image_height;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic [15:0] column;
        logic [15:0] row;
        logic        last_pixel;
    } result_t;

    // fixed header bytes 1..11: 00 02 00 00 00 00 00 00 00 00 00
    function automatic logic [7:0] pattern_byte(input logic [4:0] hdr_idx);
        logic [7:0] val;
        val = 8'h00;
        if (hdr_idx == 5'd2)
        begin
            val = 8'h02;
        end
        return val;
    endfunction

endpackage

>>> hdl/tga_in_stage.sv
`timescale 1ns / 1ps

// Input register: takes a byte whenever empty or being consumed this cycle.
module tga_in_stage (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [7:0]    s_tdata,
    input  logic          s_tuser,
    input  logic          advance,
    output logic          item_valid,
    output tga_pkg::item_t item
);

    logic            valid_reg;
    logic            valid_next;
    tga_pkg::item_t  item_reg;

    assign s_tready   = !valid_reg || advance;
    assign valid_next = s_tready ? s_tvalid : valid_reg;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            item_reg.data_byte     <= s_tdata;
            item_reg.start_of_file <= s_tuser;
        end
    end

endmodule

>>> hdl/tga_parse.sv
`timescale 1ns / 1ps

// Header check, ID skip and pixel assembly; state moves on each advance.
module tga_parse (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  tga_pkg::item_t    item,
    output logic              res_valid,
    output tga_pkg::result_t  res
);

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_HEADER = 3'd1,
        PH_DESC   = 3'd2,
        PH_ID     = 3'd3,
        PH_PIXELS = 3'd4
    } phase_t;

    phase_t      phase_reg,      phase_next;
    logic [4:0]  hdr_idx_reg,    hdr_idx_next;
    logic [7:0]  id_rem_reg,     id_rem_next;
    logic [15:0] width_reg,      width_next;
    logic [15:0] height_reg,     height_next;
    logic        four_reg,       four_next;
    logic [1:0]  pix_idx_reg,    pix_idx_next;
    logic [23:0] held_reg,       held_next;
    logic [15:0] col_reg,        col_next;
    logic [15:0] row_reg,        row_next;

    logic [7:0]  b;
    logic [1:0]  last_idx;
    logic [23:0] full_pix;
    logic        col_end;
    logic        row_end;
    logic [7:0]  id_dec;

    assign b        = item.data_byte;
    assign last_idx = four_reg ? 2'd3 : 2'd2;
    assign full_pix = four_reg ? held_reg : (held_reg | {b, 16'h0000});
    assign col_end  = (col_reg == (width_reg - 16'd1));
    assign row_end  = (row_reg == (height_reg - 16'd1));
    assign id_dec   = id_rem_reg - 8'd1;

    always_comb
    begin
        phase_next   = phase_reg;
        hdr_idx_next = hdr_idx_reg;
        id_rem_next  = id_rem_reg;
        width_next   = width_reg;
        height_next  = height_reg;
        four_next    = four_reg;
        pix_idx_next = pix_idx_reg;
        held_next    = held_reg;
        col_next     = col_reg;
        row_next     = row_reg;
        res_valid    = 1'b0;
        res          = '0;

        if (item.start_of_file)
        begin
            phase_next   = PH_HEADER;
            hdr_idx_next = 5'd1;
            id_rem_next  = b;
            width_next   = '0;
            height_next  = '0;
            four_next    = 1'b0;
            pix_idx_next = '0;
            held_next    = '0;
            col_next     = '0;
            row_next     = '0;
        end
        else
        begin
            unique case (phase_reg)
                PH_HEADER:
                begin
                    if (hdr_idx_reg < 5'(tga_pkg::HDR_LEN))
                    begin
                        if (b != tga_pkg::pattern_byte(hdr_idx_reg))
                        begin
                            res_valid      = 1'b1;
                            res.kind       = tga_pkg::KIND_ERROR;
                            res.error_code = tga_pkg::ERR_MISMATCH;
                            phase_next     = PH_IDLE;
                        end
                        else
                        begin
                            hdr_idx_next = hdr_idx_reg + 5'd1;
                        end
                    end
                    else if (hdr_idx_reg == 5'(tga_pkg::HDR_LEN))
                    begin
                        width_next   = {8'h00, b};
                        hdr_idx_next = hdr_idx_reg + 5'd1;
                    end
                    else if (hdr_idx_reg == 5'(tga_pkg::HDR_LEN + 1))
                    begin
                        width_next   = {b, width_reg[7:0]};
                        hdr_idx_next = hdr_idx_reg + 5'd1;
                    end
                    else if (hdr_idx_reg == 5'(tga_pkg::HDR_LEN + 2))
                    begin
                        height_next  = {8'h00, b};
                        hdr_idx_next = hdr_idx_reg + 5'd1;
                    end
                    else if (hdr_idx_reg == 5'(tga_pkg::HDR_LEN + 3))
                    begin
                        height_next  = {b, height_reg[7:0]};
                        hdr_idx_next = hdr_idx_reg + 5'd1;
                    end
                    else
                    begin
                        // depth byte: size check wins over depth check
                        res_valid = 1'b1;
                        if (width_reg == '0 || height_reg == '0)
                        begin
                            res.kind       = tga_pkg::KIND_ERROR;
                            res.error_code = tga_pkg::ERR_SIZE;
                            phase_next     = PH_IDLE;
                        end
                        else if (b != tga_pkg::DEPTH_24 && b != tga_pkg::DEPTH_32)
                        begin
                            res.kind       = tga_pkg::KIND_ERROR;
                            res.error_code = tga_pkg::ERR_DEPTH;
                            phase_next     = PH_IDLE;
                        end
                        else
                        begin
                            four_next        = (b == tga_pkg::DEPTH_32);
                            phase_next       = PH_DESC;
                            res.kind         = tga_pkg::KIND_HEADER;
                            res.image_width  = width_reg;
                            res.image_height = height_reg;
                        end
                    end
                end
                PH_DESC:
                begin
                    phase_next = (id_rem_reg != '0) ? PH_ID : PH_PIXELS;
                end
                PH_ID:
                begin
                    id_rem_next = id_dec;
                    if (id_dec == '0)
                    begin
                        phase_next = PH_PIXELS;
                    end
                end
                PH_PIXELS:
                begin
                    if (pix_idx_reg < last_idx)
                    begin
                        unique case (pix_idx_reg)
                            2'd0:    held_next = held_reg | {16'h0000, b};
                            2'd1:    held_next = held_reg | {8'h00, b, 8'h00};
                            default: held_next = held_reg | {b, 16'h0000};
                        endcase
                        pix_idx_next = pix_idx_reg + 2'd1;
                    end
                    else
                    begin
                        res_valid      = 1'b1;
                        res.kind       = tga_pkg::KIND_PIXEL;
                        res.red        = full_pix[23:16];
                        res.green      = full_pix[15:8];
                        res.blue       = full_pix[7:0];
                        res.alpha      = four_reg ? b : tga_pkg::OPAQUE;
                        res.column     = col_reg;
                        res.row        = row_reg;
                        res.last_pixel = col_end && row_end;
                        held_next      = '0;
                        pix_idx_next   = '0;
                        if (col_end && row_end)
                        begin
                            phase_next = PH_IDLE;
                        end
                        else if (col_end)
                        begin
                            col_next = '0;
                            row_next = row_reg + 16'd1;
                        end
                        else
                        begin
                            col_next = col_reg + 16'd1;
                        end
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            hdr_idx_reg <= '0;
            id_rem_reg  <= '0;
            width_reg   <= '0;
            height_reg  <= '0;
            four_reg    <= 1'b0;
            pix_idx_reg <= '0;
            held_reg    <= '0;
            col_reg     <= '0;
            row_reg     <= '0;
        end
        else if (advance)
        begin
            phase_reg   <= phase_next;
            hdr_idx_reg <= hdr_idx_next;
            id_rem_reg  <= id_rem_next;
            width_reg   <= width_next;
            height_reg  <= height_next;
            four_reg    <= four_next;
            pix_idx_reg <= pix_idx_next;
            held_reg    <= held_next;
            col_reg     <= col_next;
            row_reg     <= row_next;
        end
    end

endmodule

>>> hdl/tga_out_stage.sv
`timescale 1ns / 1ps

// Result register and stream packing.
module tga_out_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  logic              res_valid,
    input  tga_pkg::result_t  res,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [tga_pkg::TDATA_BITS-1:0] m_tdata,
    output logic [1:0]        m_tuser,
    output logic              m_tlast
);

    logic              valid_reg;
    logic              valid_next;
    tga_pkg::result_t  res_reg;

    assign valid_next = advance ? res_valid : (valid_reg && !m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && res_valid)
        begin
            res_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tuser  = res_reg.kind;
    assign m_tlast  = res_reg.last_pixel;
    assign m_tdata  = {6'd0, res_reg.row, res_reg.column, res_reg.alpha, res_reg.blue,
                       res_reg.green, res_reg.red, res_reg.image_height,
                       res_reg.image_width, res_reg.error_code};

endmodule

>>> hdl/tga_truecolor_stream_parser_unit.sv
`timescale 1ns / 1ps

// Uncompressed truecolor TGA parser. Feed the file one byte per transfer on
// the slave side, with s_tuser high on byte 0 of each file (that byte is the
// ID length and always restarts parsing). The 18-byte header is checked: a
// wrong fixed byte gives an error result, and the depth byte gives a header
// result (width, height) or a size or depth error result. After an error, the
// last pixel or reset, bytes are ignored until the next start of file. The ID
// field and descriptor byte are skipped, then each BGR or BGRA pixel yields
// one RGBA pixel result with its column, row and tlast on the final pixel of
// the image. Throughput is one byte per clock while the sink keeps up; a byte
// passes the input register and the result register around a single pass of
// parser logic. The result register can drain and reload in the same cycle,
// so the input is only held off while both the input and result registers
// are full and the sink is not ready.
module tga_truecolor_stream_parser_unit (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] data_byte
    input  logic         s_tuser,   // [0] start_of_file
    output logic         m_tvalid,
    input  logic         m_tready,
    // [1:0] error_code, [17:2] image_width, [33:18] image_height,
    // [41:34] red, [49:42] green, [57:50] blue, [65:58] alpha,
    // [81:66] column, [97:82] row, [103:98] zero
    output logic [103:0] m_tdata,
    output logic [1:0]   m_tuser,   // [1:0] kind
    output logic         m_tlast    // last_pixel
);

    logic              item_valid;
    tga_pkg::item_t    item;
    logic              advance;
    logic              res_valid;
    tga_pkg::result_t  res;

    // the held byte moves on when the result slot is free or draining
    assign advance = item_valid && (!m_tvalid || m_tready);

    tga_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    tga_parse u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .item      (item),
        .res_valid (res_valid),
        .res       (res)
    );

    tga_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .res_valid (res_valid),
        .res       (res),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // tlast only ever marks a pixel
    a_last_is_pixel : assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tuser == tga_pkg::KIND_PIXEL)
        else $error("tlast on non-pixel result");

    // an error code is present exactly on error results
    a_err_code : assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((m_tuser == tga_pkg::KIND_ERROR) ==
                      (m_tdata[1:0] != tga_pkg::ERR_NONE)))
        else $error("error code does not match result kind");

    // both registers full and output stalled: input must be held off
    a_backpressure : assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && m_tvalid && !m_tready |-> !s_tready)
        else $error("input accepted with both stages full");

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int LONG_HOLD   = 80;      // cycles the sink holds off to back up the parser
    localparam int BYTE_TARGET = 1700;    // parsed bytes, directed cases included, that end the random part
    localparam int CALM_FROM   = 1450;    // no idling on either side from here on

    // Fixed header bytes 1..11: image type 2, no colour map, zero origin
    localparam logic [7:0] SIGNATURE [0:10] = '{8'h00, 8'h02, 8'h00, 8'h00, 8'h00, 8'h00,
                                                8'h00, 8'h00, 8'h00, 8'h00, 8'h00};

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HEADER,
        ST_DESC,
        ST_ID,
        ST_PIXELS
    } parse_state_t;

    // Tracks the parser byte by byte and holds the results it should produce,
    // oldest first.
    class tga_decode_tracker;
        parse_state_t     state;
        logic [4:0]       hdr_pos;
        logic [7:0]       id_left;
        logic [15:0]      width;
        logic [15:0]      height;
        bit               four_bytes;
        logic [1:0]       pix_pos;
        logic [23:0]      held;
        logic [15:0]      col;
        logic [15:0]      row_no;
        tga_pkg::result_t pending_results[$];
        int               mismatches;
        int               bytes_parsed;

        function new();
            clear();
            mismatches   = 0;
            bytes_parsed = 0;
        endfunction

        function void clear();
            state      = ST_IDLE;
            hdr_pos    = '0;
            id_left    = '0;
            width      = '0;
            height     = '0;
            four_bytes = 1'b0;
            pix_pos    = '0;
            held       = '0;
            col        = '0;
            row_no     = '0;
        endfunction

        function void take_byte(logic [7:0] b, logic sof);
            tga_pkg::result_t res;
            bit               produced;
            bit               at_end;
            res      = '0;
            produced = 1'b0;
            if (sof || state != ST_IDLE)
                bytes_parsed++;
            // start of file wins over everything, even mid-pixel
            if (sof)
            begin
                clear();
                id_left = b;
                hdr_pos = 5'd1;
                state   = ST_HEADER;
                return;
            end
            case (state)
                ST_HEADER:
                begin
                    if (hdr_pos < tga_pkg::HDR_LEN)
                    begin
                        if (b != SIGNATURE[hdr_pos - 5'd1])
                        begin
                            res.kind       = tga_pkg::KIND_ERROR;
                            res.error_code = tga_pkg::ERR_MISMATCH;
                            produced       = 1'b1;
                        end
                    end
                    else if (hdr_pos == tga_pkg::HDR_LEN)
                        width = {8'h00, b};
                    else if (hdr_pos == tga_pkg::HDR_LEN + 1)
                        width[15:8] = b;
                    else if (hdr_pos == tga_pkg::HDR_LEN + 2)
                        height = {8'h00, b};
                    else if (hdr_pos == tga_pkg::HDR_LEN + 3)
                        height[15:8] = b;
                    else
                    begin
                        // depth byte: size check before depth check
                        produced = 1'b1;
                        if (width == 16'd0 || height == 16'd0)
                        begin
                            res.kind       = tga_pkg::KIND_ERROR;
                            res.error_code = tga_pkg::ERR_SIZE;
                        end
                        else if (b != tga_pkg::DEPTH_24 && b != tga_pkg::DEPTH_32)
                        begin
                            res.kind       = tga_pkg::KIND_ERROR;
                            res.error_code = tga_pkg::ERR_DEPTH;
                        end
                        else
                        begin
                            res.kind         = tga_pkg::KIND_HEADER;
                            res.image_width  = width;
                            res.image_height = height;
                            four_bytes       = (b == tga_pkg::DEPTH_32);
                            state            = ST_DESC;
                        end
                    end
                    if (produced && res.kind == tga_pkg::KIND_ERROR)
                        state = ST_IDLE;
                    else if (!produced)
                        hdr_pos = hdr_pos + 5'd1;
                end
                ST_DESC:
                    state = (id_left != 8'd0) ? ST_ID : ST_PIXELS;
                ST_ID:
                begin
                    id_left = id_left - 8'd1;
                    if (id_left == 8'd0)
                        state = ST_PIXELS;
                end
                ST_PIXELS:
                begin
                    if (pix_pos < (four_bytes ? 2'd3 : 2'd2))
                    begin
                        held[8 * pix_pos +: 8] = b;
                        pix_pos = pix_pos + 2'd1;
                    end
                    else
                    begin
                        if (four_bytes)
                            res.alpha = b;
                        else
                        begin
                            held[23:16] = b;
                            res.alpha   = tga_pkg::OPAQUE;
                        end
                        at_end = (col == width - 16'd1) && (row_no == height - 16'd1);
                        res.kind       = tga_pkg::KIND_PIXEL;
                        res.red        = held[23:16];
                        res.green      = held[15:8];
                        res.blue       = held[7:0];
                        res.column     = col;
                        res.row        = row_no;
                        res.last_pixel = at_end;
                        produced       = 1'b1;
                        held           = '0;
                        pix_pos        = '0;
                        if (at_end)
                            state = ST_IDLE;
                        else if (col == width - 16'd1)
                        begin
                            col    = '0;
                            row_no = row_no + 16'd1;
                        end
                        else
                            col = col + 16'd1;
                    end
                end
                default:
                    ;
            endcase
            if (produced)
                pending_results.push_back(res);
        endfunction

        function void compare(string what, logic [15:0] want, logic [15:0] got);
            if (want !== got)
            begin
                $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
                mismatches++;
            end
        endfunction

        function void check_output(logic [103:0] data, logic [1:0] user, logic tlast);
            tga_pkg::result_t want;
            if (pending_results.size() == 0)
            begin
                $display("%0t: result with none expected, expected nothing, %s %0d data %h",
                         $time, "actual kind", user, data);
                mismatches++;
                return;
            end
            want = pending_results.pop_front();
            compare("kind", 16'(want.kind), 16'(user));
            compare("error_code", 16'(want.error_code), 16'(data[1:0]));
            compare("image_width", want.image_width, data[17:2]);
            compare("image_height", want.image_height, data[33:18]);
            compare("red", 16'(want.red), 16'(data[41:34]));
            compare("green", 16'(want.green), 16'(data[49:42]));
            compare("blue", 16'(want.blue), 16'(data[57:50]));
            compare("alpha", 16'(want.alpha), 16'(data[65:58]));
            compare("column", want.column, data[81:66]);
            compare("row", want.row, data[97:82]);
            compare("last_pixel", 16'(want.last_pixel), 16'(tlast));
        endfunction
    endclass

    logic         clk      = 1'b0;
    logic         rst_n    = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [7:0]   s_tdata  = 8'h00;   // [7:0] data_byte
    logic         s_tuser  = 1'b0;    // [0] start_of_file
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    // [1:0] error_code, [17:2] image_width, [33:18] image_height, [41:34] red,
    // [49:42] green, [57:50] blue, [65:58] alpha, [81:66] column, [97:82] row
    logic [103:0] m_tdata;
    logic [1:0]   m_tuser;            // [1:0] kind
    logic         m_tlast;            // last_pixel

    tga_decode_tracker tracker = new();

    bit calm     = 1'b0;   // set for the closing stretch: no idling either side
    bit hold_req = 1'b0;   // asks the sink for one long hold-off

    tga_truecolor_stream_parser_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #5 clk = ~clk;

    // Result side: every transfer is checked against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            tracker.check_output(m_tdata, m_tuser, m_tlast);
    end

    // Sink: random back-pressure bursts, plus one long hold-off when asked
    initial
    begin
        int stall;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                m_tready <= 1'b1;
            end
            else if (!calm && $urandom_range(0, 7) == 0)
            begin
                stall = $urandom_range(1, 10);
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
                m_tready <= 1'b1;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // One byte transfer; tvalid is left high so a following call can go
    // straight on in the same cycle.
    task automatic send_byte(input logic [7:0] b, input logic sof);
        int gap;
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 10);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= sof;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        tracker.take_byte(b, sof);
    endtask

    // 18-byte header; a position 1..17 in bad_pos has its byte replaced
    task automatic send_header(input logic [7:0] id_len, input logic [15:0] w,
                               input logic [15:0] h, input logic [7:0] depth,
                               input int bad_pos, input logic [7:0] bad_val);
        logic [7:0] hdr [0:17];
        int         i;
        hdr[0] = id_len;
        for (i = 1; i < tga_pkg::HDR_LEN; i++)
            hdr[i] = SIGNATURE[i - 1];
        hdr[12] = w[7:0];
        hdr[13] = w[15:8];
        hdr[14] = h[7:0];
        hdr[15] = h[15:8];
        hdr[16] = depth;
        hdr[17] = 8'($urandom_range(0, 255));
        if (bad_pos >= 1 && bad_pos <= 17)
            hdr[bad_pos] = bad_val;
        for (i = 0; i < 18; i++)
            send_byte(hdr[i], i == 0);
    endtask

    // ID field then pixel bytes; fill < 0 gives random pixel bytes, cut >= 0
    // truncates the body after that many bytes
    task automatic send_body(input int id_len, input longint pixels, input bit four,
                             input int fill, input longint cut);
        longint total;
        longint k;
        total = id_len + pixels * (four ? 4 : 3);
        if (cut >= 0 && cut < total)
            total = cut;
        for (k = 0; k < total; k++)
        begin
            if (fill < 0 || k < id_len)
                send_byte(8'($urandom_range(0, 255)), 1'b0);
            else
                send_byte(fill[7:0], 1'b0);
        end
    endtask

    task automatic send_noise(input int count, input bit allow_start);
        int k;
        for (k = 0; k < count; k++)
            send_byte(8'($urandom_range(0, 255)),
                      allow_start && $urandom_range(0, 3) == 0);
    endtask

    task automatic send_file(input int id_len, input logic [15:0] w, input logic [15:0] h,
                             input logic [7:0] depth, input int fill, input longint cut,
                             input int trail);
        send_header(8'(id_len), w, h, depth, 0, 8'h00);
        send_body(id_len, longint'(w) * longint'(h), depth == tga_pkg::DEPTH_32, fill, cut);
        send_noise(trail, 1'b0);
    endtask

    // Stop offering and wait until every expected result has been seen
    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (tracker.pending_results.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int file_no;
        int pick;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // directed cases
        send_noise(2, 1'b0);                                           // ignored while idle
        send_header(8'd0, 16'd1, 16'd1, tga_pkg::DEPTH_24, 1, 8'h01);  // first fixed byte wrong
        send_header(8'd0, 16'd1, 16'd1, tga_pkg::DEPTH_24, 2, 8'h00);  // image type wrong
        send_header(8'd0, 16'd1, 16'd1, tga_pkg::DEPTH_24, 11, 8'h80); // last fixed byte wrong
        send_header(8'd0, 16'd0, 16'd5, 8'd7, 0, 8'h00);       // zero width beats bad depth
        send_header(8'd0, 16'd5, 16'd0, tga_pkg::DEPTH_32, 0, 8'h00);  // zero height
        send_header(8'd0, 16'd1, 16'd1, 8'd16, 0, 8'h00);      // unsupported depth
        send_file(0, 16'd1, 16'd1, tga_pkg::DEPTH_24, 255, -1, 2);     // one pixel, trailing
        send_file(2, 16'd2, 16'd2, tga_pkg::DEPTH_32, 0, -1, 0);       // all-zero pixels
        send_file(255, 16'd1, 16'd1, tga_pkg::DEPTH_32, 255, -1, 0);   // longest ID field
        send_file(1, 16'hFFFF, 16'hFFFF, tga_pkg::DEPTH_32, -1, 5, 0); // largest, cut short
        send_file(0, 16'd3, 16'd1, tga_pkg::DEPTH_24, -1, 4, 0);       // partial pixel

        // random files, mostly well formed
        file_no = 0;
        while (tracker.bytes_parsed < BYTE_TARGET)
        begin
            if (tracker.bytes_parsed >= CALM_FROM)
                calm = 1'b1;
            pick = $urandom_range(0, 99);
            if (file_no == 4)
            begin
                // sink holds off during the pixels so the input side backs up
                send_header(8'd0, 16'd4, 16'd3, tga_pkg::DEPTH_32, 0, 8'h00);
                hold_req = 1'b1;
                send_body(0, 12, 1'b1, -1, -1);
            end
            else if (file_no % 40 == 20)
            begin
                wait_results_drained();
                send_file(int'($urandom_range(0, 3)), 16'($urandom_range(1, 4)),
                          16'($urandom_range(1, 3)),
                          $urandom_range(0, 1) ? tga_pkg::DEPTH_32 : tga_pkg::DEPTH_24,
                          -1, -1, 0);
            end
            else if (pick < 62)
                send_file(($urandom_range(0, 9) == 0) ? int'($urandom_range(4, 40))
                                                      : int'($urandom_range(0, 3)),
                          16'($urandom_range(1, 4)), 16'($urandom_range(1, 3)),
                          $urandom_range(0, 1) ? tga_pkg::DEPTH_32 : tga_pkg::DEPTH_24, -1,
                          ($urandom_range(0, 7) == 0) ? longint'($urandom_range(0, 30))
                                                      : longint'(-1),
                          ($urandom_range(0, 3) == 0) ? int'($urandom_range(1, 3)) : 0);
            else if (pick < 80)
                send_header(8'($urandom_range(0, 255)), 16'($urandom_range(1, 4)),
                            16'($urandom_range(1, 3)), tga_pkg::DEPTH_24,
                            int'($urandom_range(1, 16)), 8'($urandom_range(0, 255)));
            else if (pick < 90)
                // any size at all, including zero; body cut short
                send_file(int'($urandom_range(0, 2)), 16'($urandom_range(0, 65535)),
                          16'($urandom_range(0, 65535)),
                          ($urandom_range(0, 2) == 0) ? 8'($urandom_range(0, 255))
                                                      : ($urandom_range(0, 1) ? 8'd32
                                                                              : 8'd24),
                          -1, longint'($urandom_range(0, 8)), 0);
            else
                send_noise(int'($urandom_range(1, 5)), 1'b1);
            file_no++;
        end

        wait_results_drained();
        repeat (8) @(posedge clk);
        if (tracker.mismatches == 0 && tracker.pending_results.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Watchdog, many times the slowest correct run
    initial
    begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule

>>> sim.f
hdl/tga_pkg.sv
hdl/tga_in_stage.sv
hdl/tga_parse.sv
hdl/tga_out_stage.sv
hdl/tga_truecolor_stream_parser_unit.sv
bench/tb.sv
